### src/wps_pkg.sv
// package for the waypoint projection sorter
// holds default sizes, port widths and the result status codes; no dependencies
package wps_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_BITS_DEF = 24;
  localparam int PORT_COORD_W   = 24;
  localparam int INDEX_W        = 6;
  localparam int STATUS_W       = 3;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_TOO_FEW  = 3'd1,
    ST_ZERO_LEN = 3'd2,
    ST_BEHIND   = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_t;

endpackage

### src/waypoint_projection_sorter.sv
// waypoint projection sorter top level
// depends on wps_pkg; holds the point and key memories and the sequencer
//
// usage:
//   input channel (in_valid/in_ready) takes one point word per accepted
//   cycle; in_final_point marks the last point of a list. non-final points
//   are stored with no result word. points beyond MAX_POINTS are dropped and
//   the run reports overflow.
//   after the final point the block leaves the load state and in_ready stays
//   low until the last result word of the run has been taken.
//   result channel (out_valid/out_ready) gives either one error word
//   (run_end set) or the ordered index list: start, middle points by
//   ascending projection, end (run_end on the last word).
//   timing: loading is one point per accepted cycle. after judging, each
//   middle point goes through the shared multiplier in the steps fetch,
//   three products and sum. ordering is a selection pass over the key
//   memory per middle word: a read and compare step per middle point, then
//   a pick step that sends the word.
//   a stalled receiver simply holds the sequencer in its wait state.
//   reset clears the sequencer, point count and overflow flag; the memories
//   are not cleared since only written entries are ever read.
module waypoint_projection_sorter
  import wps_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [wps_pkg::PORT_COORD_W-1:0] in_pos_x,
  input  logic signed [wps_pkg::PORT_COORD_W-1:0] in_pos_y,
  input  logic signed [wps_pkg::PORT_COORD_W-1:0] in_pos_z,
  input  logic                                 in_final_point,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [wps_pkg::INDEX_W-1:0]          out_point_index,
  output logic [wps_pkg::STATUS_W-1:0]         out_status,
  output logic                                 out_run_end
);

  localparam int C      = COORD_BITS;
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int IDX_W  = $clog2(MAX_POINTS);
  localparam int PROD_W = 2 * C + 2;
  localparam int KEY_W  = 2 * C + 4;

  typedef enum logic [3:0] {
    S_LOAD, S_JUDGE, S_FETCH, S_MX, S_MY, S_MZ, S_SUM,
    S_SRD, S_SCMP, S_PICK, S_LAST, S_WAIT
  } state_t;

  state_t state_r, ret_r;

  // point count and overflow of the list being loaded
  logic [CNT_W-1:0] cnt_r, n_r, em_r;
  logic             ovf_r;
  logic [IDX_W-1:0] i_r;

  // line ends and line vector
  logic signed [C-1:0] p0_r [3];
  logic signed [C-1:0] pl_r [3];
  logic signed [C:0]   v_r  [3];

  // memories
  logic [3*C-1:0]   coord_mem [MAX_POINTS];
  logic [KEY_W-1:0] key_mem   [MAX_POINTS];
  logic [3*C-1:0]   rd_coord_r;
  logic [KEY_W-1:0] rd_key_r;

  // shared multiplier and accumulator
  logic signed [PROD_W-1:0] prod_r;
  logic signed [KEY_W-1:0]  acc_r;

  // selection pass state
  logic [KEY_W-1:0] prev_key_r, best_key_r;
  logic [IDX_W-1:0] prev_j_r, best_j_r;
  logic             first_r, best_v_r;

  // output register
  logic                out_valid_r, out_run_end_r;
  logic [INDEX_W-1:0]  out_index_r;
  status_t             out_status_r;

  // input coordinates: low C bits of the port, zero-extended when C exceeds the port width
  logic [55:0]         wide_x, wide_y, wide_z;
  logic signed [C-1:0] in_c [3];
  assign wide_x = {32'b0, in_pos_x};
  assign wide_y = {32'b0, in_pos_y};
  assign wide_z = {32'b0, in_pos_z};
  assign in_c[0] = wide_x[C-1:0];
  assign in_c[1] = wide_y[C-1:0];
  assign in_c[2] = wide_z[C-1:0];

  logic in_acc, cnt_room;
  assign in_ready = (state_r == S_LOAD);
  assign in_acc   = in_valid && in_ready;
  assign cnt_room = cnt_r < CNT_W'(MAX_POINTS);

  // line vector as seen from the registered ends
  logic signed [C:0] v_nxt [3];
  logic              v_zero;
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      v_nxt[j] = (C+1)'(pl_r[j]) - (C+1)'(p0_r[j]);
    end
    v_zero = (v_nxt[0] == '0) && (v_nxt[1] == '0) && (v_nxt[2] == '0);
  end

  // multiplier operands, one axis per state
  logic signed [C-1:0] rd_c [3];
  logic signed [C:0]   mul_a, mul_b;
  logic [1:0]          axis;
  assign rd_c[0] = rd_coord_r[C-1:0];
  assign rd_c[1] = rd_coord_r[2*C-1:C];
  assign rd_c[2] = rd_coord_r[3*C-1:2*C];
  always_comb begin
    unique case (state_r)
      S_MY:    axis = 2'd1;
      S_MZ:    axis = 2'd2;
      default: axis = 2'd0;
    endcase
    mul_a = v_r[axis];
    mul_b = (C+1)'(rd_c[axis]) - (C+1)'(p0_r[axis]);
  end

  logic signed [KEY_W-1:0] key_sum;
  assign key_sum = acc_r + KEY_W'(prod_r);

  // candidate must come after the previous pick and before the current best
  logic after_prev, before_best;
  assign after_prev  = first_r || (rd_key_r > prev_key_r) ||
                       ((rd_key_r == prev_key_r) && (i_r > prev_j_r));
  assign before_best = !best_v_r || (rd_key_r < best_key_r);

  logic last_mid;
  assign last_mid = (CNT_W'(i_r) == n_r - CNT_W'(2));

  // memories
  always_ff @(posedge clk) begin
    if (in_acc && cnt_room) begin
      coord_mem[cnt_r[IDX_W-1:0]] <= {in_c[2], in_c[1], in_c[0]};
    end
    if (state_r == S_SUM) begin
      key_mem[i_r] <= key_sum;
    end
    rd_coord_r <= coord_mem[i_r];
    rd_key_r   <= key_mem[i_r];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      ret_r       <= S_LOAD;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_LOAD: begin
          if (in_acc) begin
            if (cnt_room && (cnt_r == '0)) begin
              p0_r <= in_c;
            end
            if (in_final_point) begin
              n_r     <= cnt_r + CNT_W'(cnt_room);
              ovf_r   <= ovf_r || !cnt_room;
              pl_r    <= in_c;
              cnt_r   <= '0;
              state_r <= S_JUDGE;
            end else if (cnt_room) begin
              cnt_r <= cnt_r + CNT_W'(1);
            end else begin
              ovf_r <= 1'b1;
            end
          end
        end
        S_JUDGE: begin
          v_r   <= v_nxt;
          ovf_r <= 1'b0;
          i_r   <= IDX_W'(1);
          out_index_r   <= '0;
          out_run_end_r <= 1'b1;
          priority if (ovf_r) begin
            out_status_r <= ST_OVERFLOW;
            out_valid_r  <= 1'b1;
            ret_r        <= S_LOAD;
            state_r      <= S_WAIT;
          end else if (n_r < CNT_W'(2)) begin
            out_status_r <= ST_TOO_FEW;
            out_valid_r  <= 1'b1;
            ret_r        <= S_LOAD;
            state_r      <= S_WAIT;
          end else if (v_zero) begin
            out_status_r <= ST_ZERO_LEN;
            out_valid_r  <= 1'b1;
            ret_r        <= S_LOAD;
            state_r      <= S_WAIT;
          end else if (n_r == CNT_W'(2)) begin
            out_status_r  <= ST_OK;
            out_run_end_r <= 1'b0;
            out_valid_r   <= 1'b1;
            ret_r         <= S_LAST;
            state_r       <= S_WAIT;
          end else begin
            state_r <= S_FETCH;
          end
        end
        S_FETCH: state_r <= S_MX;
        S_MX: begin
          prod_r  <= mul_a * mul_b;
          state_r <= S_MY;
        end
        S_MY: begin
          acc_r   <= KEY_W'(prod_r);
          prod_r  <= mul_a * mul_b;
          state_r <= S_MZ;
        end
        S_MZ: begin
          acc_r   <= key_sum;
          prod_r  <= mul_a * mul_b;
          state_r <= S_SUM;
        end
        S_SUM: begin
          priority if (key_sum[KEY_W-1]) begin
            out_index_r   <= INDEX_W'(i_r);
            out_status_r  <= ST_BEHIND;
            out_run_end_r <= 1'b1;
            out_valid_r   <= 1'b1;
            ret_r         <= S_LOAD;
            state_r       <= S_WAIT;
          end else if (last_mid) begin
            // all keys in place: send the start, then the ordering pass
            out_index_r   <= '0;
            out_status_r  <= ST_OK;
            out_run_end_r <= 1'b0;
            out_valid_r   <= 1'b1;
            i_r           <= IDX_W'(1);
            first_r       <= 1'b1;
            best_v_r      <= 1'b0;
            em_r          <= '0;
            ret_r         <= S_SRD;
            state_r       <= S_WAIT;
          end else begin
            i_r     <= i_r + IDX_W'(1);
            state_r <= S_FETCH;
          end
        end
        S_SRD: state_r <= S_SCMP;
        S_SCMP: begin
          if (after_prev && before_best) begin
            best_v_r   <= 1'b1;
            best_key_r <= rd_key_r;
            best_j_r   <= i_r;
          end
          if (last_mid) begin
            state_r <= S_PICK;
          end else begin
            i_r     <= i_r + IDX_W'(1);
            state_r <= S_SRD;
          end
        end
        S_PICK: begin
          out_index_r   <= INDEX_W'(best_j_r);
          out_status_r  <= ST_OK;
          out_run_end_r <= 1'b0;
          out_valid_r   <= 1'b1;
          prev_key_r    <= best_key_r;
          prev_j_r      <= best_j_r;
          first_r       <= 1'b0;
          best_v_r      <= 1'b0;
          i_r           <= IDX_W'(1);
          em_r          <= em_r + CNT_W'(1);
          ret_r         <= (em_r + CNT_W'(1) == n_r - CNT_W'(2)) ? S_LAST : S_SRD;
          state_r       <= S_WAIT;
        end
        S_LAST: begin
          out_index_r   <= INDEX_W'(n_r - CNT_W'(1));
          out_status_r  <= ST_OK;
          out_run_end_r <= 1'b1;
          out_valid_r   <= 1'b1;
          ret_r         <= S_LOAD;
          state_r       <= S_WAIT;
        end
        S_WAIT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            state_r     <= ret_r;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_point_index = out_index_r;
  assign out_status      = out_status_r;
  assign out_run_end     = out_run_end_r;

  // result word only ever shown while waiting on the receiver
  a_valid_wait: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == S_WAIT) else $error("result word outside wait state");
  // input and output never both open
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input open while result pending");
  // every error word closes the run
  a_err_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_run_end) else $error("error word without run end");
  // point count stays within the store
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_POINTS)) else $error("point count beyond store");

endmodule

### dv/tb.sv
// testbench for waypoint_projection_sorter: point lists in, ordered index words out
// depends on wps_pkg and the block; self-checking against an internal projection sorter
`timescale 1ns / 1ps

module tb;
  import wps_pkg::*;

  localparam int NPTS = 64;
  localparam int WD_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [PORT_COORD_W-1:0] in_pos_x = '0;
  logic signed [PORT_COORD_W-1:0] in_pos_y = '0;
  logic signed [PORT_COORD_W-1:0] in_pos_z = '0;
  logic in_final_point = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [INDEX_W-1:0] out_point_index;
  logic [STATUS_W-1:0] out_status;
  logic out_run_end;

  waypoint_projection_sorter i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .in_final_point(in_final_point),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_point_index(out_point_index), .out_status(out_status),
    .out_run_end(out_run_end)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  typedef struct packed {
    logic [INDEX_W-1:0] idx;
    status_t st;
    logic last;
  } order_word_t;

  // predictor state: the list loaded so far
  logic signed [PORT_COORD_W-1:0] list_x [NPTS];
  logic signed [PORT_COORD_W-1:0] list_y [NPTS];
  logic signed [PORT_COORD_W-1:0] list_z [NPTS];
  int list_len = 0;
  bit list_dropped = 0;
  order_word_t expected_words[$];

  int errors = 0;
  int words_seen = 0;
  int points_sent = 0;
  int runs_sent = 0;
  int idle_pct = 6;

  // projection of point i onto the line, exact in 64-bit signed math
  function automatic longint projection(int i, int n);
    longint vx, vy, vz;
    vx = longint'(list_x[n-1]) - list_x[0];
    vy = longint'(list_y[n-1]) - list_y[0];
    vz = longint'(list_z[n-1]) - list_z[0];
    return vx * (longint'(list_x[i]) - list_x[0]) + vy * (longint'(list_y[i]) - list_y[0])
         + vz * (longint'(list_z[i]) - list_z[0]);
  endfunction

  // append one expected word to the queue
  task automatic queue_word(logic [INDEX_W-1:0] idx, status_t st, logic last);
    order_word_t w;
    w.idx = idx;
    w.st = st;
    w.last = last;
    expected_words = {expected_words, w};
  endtask

  // load one point; on the final point judge the run and queue its words
  task automatic predict_point(logic signed [PORT_COORD_W-1:0] x, y, z, logic fin);
    int n;
    int mid[$];
    longint key [NPTS];
    int bad;
    if (list_len < NPTS) begin
      list_x[list_len] = x; list_y[list_len] = y; list_z[list_len] = z;
      list_len++;
    end else begin
      list_dropped = 1;
    end
    if (!fin) return;
    n = list_len;
    list_len = 0;
    if (list_dropped) begin
      list_dropped = 0;
      queue_word(INDEX_W'(0), ST_OVERFLOW, 1'b1);
      return;
    end
    if (n < 2) begin
      queue_word(INDEX_W'(0), ST_TOO_FEW, 1'b1);
      return;
    end
    if (list_x[n-1] == list_x[0] && list_y[n-1] == list_y[0] && list_z[n-1] == list_z[0]) begin
      queue_word(INDEX_W'(0), ST_ZERO_LEN, 1'b1);
      return;
    end
    bad = 0;
    for (int i = 1; i + 1 < n; i++) begin
      key[i] = projection(i, n);
      if (key[i] < 0) begin
        bad = i;
        break;
      end
    end
    if (bad != 0) begin
      queue_word(INDEX_W'(bad), ST_BEHIND, 1'b1);
      return;
    end
    // stable insertion by key, lower index first on ties
    for (int i = 1; i + 1 < n; i++) begin
      int p;
      p = mid.size();
      while (p > 0 && key[i] < key[mid[p-1]]) p--;
      mid.insert(p, i);
    end
    queue_word(INDEX_W'(0), ST_OK, 1'b0);
    foreach (mid[k]) queue_word(INDEX_W'(mid[k]), ST_OK, 1'b0);
    queue_word(INDEX_W'(n-1), ST_OK, 1'b1);
  endtask

  // send one point word, holding it until accepted
  task automatic send_point(logic signed [PORT_COORD_W-1:0] x, y, z, logic fin);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pos_x <= x; in_pos_y <= y; in_pos_z <= z;
    in_final_point <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_point(x, y, z, fin);
    points_sent++;
    if (fin) runs_sent++;
  endtask

  function automatic logic signed [PORT_COORD_W-1:0] rnd_coord();
    case ($urandom_range(3))
      0: return PORT_COORD_W'($urandom);
      1: return PORT_COORD_W'(int'($urandom_range(200)) - 100);
      2: return $urandom_range(1) ? 24'sh7fffff : 24'sh800000;
      default: return $signed(PORT_COORD_W'($urandom_range(4000000)));
    endcase
  endfunction

  // points along a line from start to end; jitter_back puts some behind the start
  task automatic send_line(int n, bit jitter_back);
    int sx, sy, sz, dx, dy, dz, t;
    sx = $signed(PORT_COORD_W'($urandom_range(200000))) - 100000;
    sy = $signed(PORT_COORD_W'($urandom_range(200000))) - 100000;
    sz = $signed(PORT_COORD_W'($urandom_range(200000))) - 100000;
    dx = $urandom_range(2000) - 1000;
    dy = $urandom_range(2000) - 1000;
    dz = $urandom_range(2000) - 1000;
    if (dx == 0 && dy == 0 && dz == 0) dx = 1;
    for (int i = 0; i < n; i++) begin
      t = (i == 0) ? 0 : (i == n - 1) ? 100 : $urandom_range(100);
      if (jitter_back && i > 0 && i < n - 1 && $urandom_range(9) == 0) t = -$urandom_range(1, 5);
      if (i > 0 && i < n - 1 && $urandom_range(7) == 0) t = $urandom_range(1) ? 50 : 20;
      send_point(PORT_COORD_W'(sx + dx * t + int'($urandom_range(2)) - 1),
                 PORT_COORD_W'(sy + dy * t),
                 PORT_COORD_W'(sz + dz * t), i == n - 1);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      order_word_t w;
      words_seen <= words_seen + 1;
      if (expected_words.size() == 0) begin
        $display("%0t unexpected word idx=%0d status=%0d end=%0b", $time,
                 out_point_index, out_status, out_run_end);
        errors <= errors + 1;
      end else begin
        w = expected_words.pop_front();
        if (w.idx !== out_point_index || w.st !== out_status || w.last !== out_run_end) begin
          $display("%0t mismatch exp idx=%0d status=%0d end=%0b act idx=%0d status=%0d end=%0b",
                   $time, w.idx, w.st, w.last, out_point_index, out_status, out_run_end);
          errors <= errors + 1;
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk) out_ready <= ($urandom_range(99) >= idle_pct);

  // watchdog on cycles with no handshake at all
  int quiet = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WD_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic test_directed();
    // single point
    send_point(24'sh7fffff, 24'sh800000, 0, 1);
    // zero length line
    send_point(5, 6, 7, 0); send_point(1, 1, 1, 0); send_point(5, 6, 7, 1);
    // two points at the extremes
    send_point(24'sh800000, 24'sh800000, 24'sh800000, 0);
    send_point(24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 1);
    // point behind start, second middle one
    send_point(0, 0, 0, 0); send_point(3, 0, 0, 0); send_point(-2, 0, 0, 0);
    send_point(-1, 9, 0, 0); send_point(10, 0, 0, 1);
    // ties and reversed order
    send_point(0, 0, 0, 0); send_point(7, 1, 0, 0); send_point(7, -1, 0, 0);
    send_point(2, 0, 0, 0); send_point(0, 0, 5, 0); send_point(10, 0, 0, 1);
  endtask

  task automatic test_overflow();
    for (int i = 0; i < NPTS + 2; i++) send_point(rnd_coord(), rnd_coord(), rnd_coord(), i == NPTS + 1);
    // exactly full list along a line, with no points set behind the start
    send_line(NPTS, 0);
  endtask

  task automatic test_random_lists();
    int pick;
    while (points_sent < 480) begin
      if (runs_sent == 20) idle_pct = 0;
      if (runs_sent == 40) idle_pct = 6;
      pick = $urandom_range(9);
      if (pick < 7) send_line($urandom_range(2, 12), 1);
      else if (pick == 7) send_line($urandom_range(13, 40), 0);
      else begin
        int n;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) send_point(rnd_coord(), rnd_coord(), rnd_coord(), i == n - 1);
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_overflow();
    test_random_lists();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("sent %0d points in %0d lists, checked %0d ordered words", points_sent,
             runs_sent, words_seen);
    $display("lists covered sorting, ties, behind-start, zero length, single point, overflow");
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
